>>> sv/afjb_pkg.sv
// Shared constants and codes for the adaptive frame jitter buffer.
package afjb_pkg;

    localparam int DEPTH_DEF         = 4096;
    localparam int PAYLOAD_BYTES_DEF = 8;

    localparam logic [7:0] FIRST_TARGET_RST = 8'd8;
    localparam logic [7:0] TARGET_STEP_RST  = 8'd4;
    localparam logic [7:0] MOST_TARGET_RST  = 8'd45;

    localparam logic [1:0] OP_STORE   = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_POLL    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] REG_FIRST_TARGET = 2'd0;
    localparam logic [1:0] REG_TARGET_STEP  = 2'd1;
    localparam logic [1:0] REG_MOST_TARGET  = 2'd2;

    localparam logic [2:0] ST_NOT_READY    = 3'd0;
    localparam logic [2:0] ST_DELIVERED    = 3'd1;
    localparam logic [2:0] ST_PASS_THROUGH = 3'd2;
    localparam logic [2:0] ST_STARTED      = 3'd3;
    localparam logic [2:0] ST_IDLE         = 3'd4;
    localparam logic [2:0] ST_STORED       = 3'd5;
    localparam logic [2:0] ST_DROPPED      = 3'd6;

    localparam logic [12:0] BUFFERED_MAX = 13'd8191;
    localparam logic [15:0] STALL_MAX    = 16'hFFFF;

endpackage

>>> sv/afjb_mod.sv
// Three-stage frame number modulo store depth, by reciprocal multiplication.
module afjb_mod #(
    parameter int DEPTH = afjb_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [30:0]   value,
    output logic          done,
    output logic [IW-1:0] idx
);
    localparam int          SHIFT = 31 + IW;
    localparam logic [63:0] RECIP = (64'd1 << SHIFT) / DEPTH;
    localparam logic [31:0] MUL_K = RECIP[31:0];
    localparam logic [31:0] DEP32 = 32'(DEPTH);

    logic [2:0]    vld_reg;
    logic [62:0]   prod_reg;
    logic [30:0]   v1_reg;
    logic [30:0]   v2_reg;
    logic [31:0]   qd_reg;
    logic [IW-1:0] idx_reg;
    logic [30:0]   quot;
    logic [47:0]   qd_full;
    logic [31:0]   rem;
    logic [31:0]   rem_fix;

    always_comb
    begin
        quot    = 31'(prod_reg >> SHIFT);
        qd_full = 48'(quot) * 48'(DEPTH);
        rem     = {1'b0, v2_reg} - qd_reg;
        // The estimated quotient is at most one short, so one correction suffices.
        rem_fix = (rem >= DEP32) ? rem - DEP32 : rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 63'(value) * 63'(MUL_K);
        v1_reg   <= value;
        qd_reg   <= qd_full[31:0];
        v2_reg   <= v1_reg;
        if (vld_reg[1])
        begin
            idx_reg <= rem_fix[IW-1:0];
        end
    end

    assign done = vld_reg[2];
    assign idx  = idx_reg;
endmodule

>>> sv/afjb_mem.sv
// Single-port frame store: tag, payload and length arrays with registered read.
module afjb_mem #(
    parameter int DEPTH = afjb_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH),
    parameter int PW    = 8 * afjb_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic          clk,
    input  logic          we_tag,
    input  logic          we_data,
    input  logic [IW-1:0] addr,
    input  logic [31:0]   tag_wr,
    input  logic [PW-1:0] pay_wr,
    input  logic [3:0]    len_wr,
    output logic [31:0]   tag_rd,
    output logic [PW-1:0] pay_rd,
    output logic [3:0]    len_rd
);
    logic [31:0]   tag_mem [DEPTH];
    logic [PW-1:0] pay_mem [DEPTH];
    logic [3:0]    len_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we_tag)
        begin
            tag_mem[addr] <= tag_wr;
        end
        tag_rd <= tag_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_data)
        begin
            pay_mem[addr] <= pay_wr;
            len_mem[addr] <= len_wr;
        end
        pay_rd <= pay_mem[addr];
        len_rd <= len_mem[addr];
    end
endmodule

>>> sv/adaptive_frame_jitter_buffer_top.sv
// From input transfer to result: poll, pass-through and a dropped store go from decode to finish;
// a request and a stored frame go through the modulo pipeline; a batch end adds an advance pass.
// One transfer is in flight at a time; the next is taken the cycle after the result is taken.
// Index computation goes through a three-stage modulo pipeline; the store is one port.
// Reset and clear run a clearing pass over every entry of the tag array; a clear then reports a result.
// Asynchronous active-low reset returns the control state, configuration and target to their reset values.
module adaptive_frame_jitter_buffer_top #(
    parameter int DEPTH         = afjb_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BYTES = afjb_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // frame_number[30:0], payload_length[34:31], payload[98:35]
    input  logic [2:0]   s_tuser,   // operation[1:0], synchronizing[2]
    input  logic         s_tlast,   // last_of_batch
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // out_length[3:0], out_payload[67:4],
                                    // newest_contiguous[99:68], buffered_count[112:100],
                                    // current_target[120:113], stall_count[136:121]
    output logic [2:0]   m_tuser,   // status[2:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = 8 * PAYLOAD_BYTES;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_DECODE, S_MODW, S_ADVS, S_ADVM, S_ADVR,
        S_MODR, S_REQR, S_FIN, S_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic [7:0]    first_reg, step_reg, most_reg;
    logic [1:0]    op_reg;
    logic [30:0]   frame_reg;
    logic [3:0]    len_reg;
    logic [63:0]   pay_reg;
    logic          last_reg, sync_reg;
    logic          clr_out_reg, clr_out_next;
    logic [IW-1:0] clr_addr_reg, clr_addr_next;
    logic [IW-1:0] adv_idx_reg, adv_idx_next;
    logic [31:0]   contig_reg, contig_next;
    logic [30:0]   consumer_reg, consumer_next;
    logic [7:0]    target_reg, target_next;
    logic [15:0]   stalls_reg, stalls_next;
    logic          buffering_reg, buffering_next;
    logic [2:0]    status_reg, status_next;
    logic [3:0]    olen_reg, olen_next;
    logic [63:0]   opay_reg, opay_next;
    logic [12:0]   buffered_reg, buffered_next;

    logic [32:0]   alu_a, alu_b;
    logic [33:0]   alu_d;
    logic          mod_start, mod_done;
    logic [30:0]   mod_val;
    logic [IW-1:0] mod_idx;
    logic          we_tag, we_data;
    logic [IW-1:0] mem_addr;
    logic [31:0]   tag_wr, tag_rd;
    logic [PW-1:0] pay_wr, pay_rd;
    logic [3:0]    len_rd;
    logic [IW-1:0] adv_inc;
    logic          len_ok, in_window, adv_hit, holds;
    logic [8:0]    tsum;
    logic [34:0]   ready_cnt;

    afjb_mod #(.DEPTH(DEPTH), .IW(IW)) u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .value(mod_val),
        .done(mod_done), .idx(mod_idx)
    );

    afjb_mem #(.DEPTH(DEPTH), .IW(IW), .PW(PW)) u_mem (
        .clk(clk), .we_tag(we_tag), .we_data(we_data), .addr(mem_addr),
        .tag_wr(tag_wr), .pay_wr(pay_wr), .len_wr(len_reg),
        .tag_rd(tag_rd), .pay_rd(pay_rd), .len_rd(len_rd)
    );

    // The one shared subtractor, its operands chosen by the sequencer state.
    always_comb
    begin
        alu_a = {contig_reg[31], contig_reg};
        alu_b = {2'b00, consumer_reg};
        case (state_reg)
            S_DECODE:
            begin
                if (op_reg == afjb_pkg::OP_STORE)
                begin
                    alu_a = {2'b00, frame_reg};
                end
                else
                begin
                    alu_b = {25'd0, target_reg};
                end
            end
            S_MODW, S_ADVS, S_ADVR: alu_b = '1;
            S_REQR:                 alu_b = {2'b00, frame_reg};
            default:                alu_b = {2'b00, consumer_reg};
        endcase
        alu_d = {alu_a[32], alu_a} - {alu_b[32], alu_b};
    end

    always_comb
    begin
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            pay_wr[8*i +: 8] = (4'(i) < len_reg) ? pay_reg[8*i +: 8] : 8'd0;
        end
        // The clearing pass writes empty tags, with the valid bit low.
        tag_wr    = (state_reg == S_CLR) ? 32'd0 : {1'b1, frame_reg};
        len_ok    = (len_reg != 4'd0) && (len_reg <= 4'(PAYLOAD_BYTES));
        in_window = !alu_d[33] && (alu_d < 34'(DEPTH));
        adv_inc   = (adv_idx_reg == IW'(DEPTH - 1)) ? '0 : adv_idx_reg + 1'b1;
        adv_hit   = (alu_d[33:31] == 3'b000) && (tag_rd == {1'b1, alu_d[30:0]});
        holds     = (tag_rd == {1'b1, frame_reg});
        tsum      = {1'b0, target_reg} + {1'b0, step_reg};
        ready_cnt = {alu_d[33], alu_d} + 35'd1;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_out_next   = clr_out_reg;
        clr_addr_next  = clr_addr_reg;
        adv_idx_next   = adv_idx_reg;
        contig_next    = contig_reg;
        consumer_next  = consumer_reg;
        target_next    = target_reg;
        stalls_next    = stalls_reg;
        buffering_next = buffering_reg;
        status_next    = status_reg;
        olen_next      = olen_reg;
        opay_next      = opay_reg;
        buffered_next  = buffered_reg;
        mod_start      = 1'b0;
        mod_val        = frame_reg;
        we_tag         = 1'b0;
        we_data        = 1'b0;
        mem_addr       = mod_idx;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    status_next = afjb_pkg::ST_IDLE;
                    olen_next   = '0;
                    opay_next   = '0;
                    if (s_tuser[1:0] == afjb_pkg::OP_CLEAR)
                    begin
                        contig_next    = '1;
                        consumer_next  = '0;
                        target_next    = first_reg;
                        stalls_next    = '0;
                        buffering_next = 1'b1;
                        clr_out_next   = 1'b1;
                        clr_addr_next  = '0;
                        state_next     = S_CLR;
                    end
                    else
                    begin
                        state_next = S_DECODE;
                    end
                end
            end
            S_CLR:
            begin
                mem_addr      = clr_addr_reg;
                we_tag        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IW'(DEPTH - 1))
                begin
                    state_next = clr_out_reg ? S_FIN : S_IDLE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    afjb_pkg::OP_STORE:
                    begin
                        status_next = afjb_pkg::ST_DROPPED;
                        if (!len_ok)
                        begin
                            state_next = S_FIN;
                        end
                        else if (in_window)
                        begin
                            status_next = afjb_pkg::ST_STORED;
                            mod_start   = 1'b1;
                            state_next  = S_MODW;
                        end
                        else
                        begin
                            state_next = last_reg ? S_ADVS : S_FIN;
                        end
                    end
                    afjb_pkg::OP_REQUEST:
                    begin
                        if (sync_reg)
                        begin
                            status_next = afjb_pkg::ST_PASS_THROUGH;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            consumer_next = frame_reg;
                            mod_start     = 1'b1;
                            state_next    = S_MODR;
                        end
                    end
                    default:
                    begin
                        // Poll: contiguous + 1 >= target means the difference is at least -1.
                        if (sync_reg && (!alu_d[33] || alu_d == '1))
                        begin
                            status_next = afjb_pkg::ST_STARTED;
                        end
                        state_next = S_FIN;
                    end
                endcase
            end
            S_MODW:
            begin
                if (mod_done)
                begin
                    we_tag     = 1'b1;
                    we_data    = 1'b1;
                    state_next = last_reg ? S_ADVS : S_FIN;
                end
            end
            S_ADVS:
            begin
                mod_val = alu_d[30:0];
                if (alu_d[33:31] == 3'b000)
                begin
                    mod_start  = 1'b1;
                    state_next = S_ADVM;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_ADVM:
            begin
                if (mod_done)
                begin
                    adv_idx_next = mod_idx;
                    state_next   = S_ADVR;
                end
            end
            S_ADVR:
            begin
                // The next index is read speculatively, so a hit moves straight on without a separate read state.
                mem_addr = adv_inc;
                if (adv_hit)
                begin
                    contig_next  = alu_d[31:0];
                    adv_idx_next = adv_inc;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MODR:
            begin
                if (mod_done)
                begin
                    state_next = S_REQR;
                end
            end
            S_REQR:
            begin
                status_next = afjb_pkg::ST_NOT_READY;
                if (!holds || alu_d[33])
                begin
                    if (!buffering_reg)
                    begin
                        buffering_next = 1'b1;
                        if (stalls_reg != afjb_pkg::STALL_MAX)
                        begin
                            stalls_next = stalls_reg + 1'b1;
                        end
                        target_next = (tsum < {1'b0, most_reg}) ? tsum[7:0] : most_reg;
                    end
                end
                else if (!(buffering_reg && ($signed(ready_cnt) < $signed({27'd0, target_reg}))))
                begin
                    buffering_next = 1'b0;
                    status_next    = afjb_pkg::ST_DELIVERED;
                    olen_next      = len_rd;
                    opay_next      = 64'(pay_rd);
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (alu_d[33])
                begin
                    buffered_next = '0;
                end
                else if (alu_d >= 34'(afjb_pkg::BUFFERED_MAX))
                begin
                    buffered_next = afjb_pkg::BUFFERED_MAX;
                end
                else
                begin
                    buffered_next = alu_d[12:0] + 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_out_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            first_reg     <= afjb_pkg::FIRST_TARGET_RST;
            step_reg      <= afjb_pkg::TARGET_STEP_RST;
            most_reg      <= afjb_pkg::MOST_TARGET_RST;
            contig_reg    <= '1;
            consumer_reg  <= '0;
            target_reg    <= afjb_pkg::FIRST_TARGET_RST;
            stalls_reg    <= '0;
            buffering_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            clr_out_reg   <= clr_out_next;
            clr_addr_reg  <= clr_addr_next;
            contig_reg    <= contig_next;
            consumer_reg  <= consumer_next;
            target_reg    <= target_next;
            stalls_reg    <= stalls_next;
            buffering_reg <= buffering_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    afjb_pkg::REG_FIRST_TARGET: first_reg <= cfg_data;
                    afjb_pkg::REG_TARGET_STEP:  step_reg  <= cfg_data;
                    afjb_pkg::REG_MOST_TARGET:  most_reg  <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            op_reg    <= s_tuser[1:0];
            sync_reg  <= s_tuser[2];
            frame_reg <= s_tdata[30:0];
            len_reg   <= s_tdata[34:31];
            pay_reg   <= s_tdata[98:35];
            last_reg  <= s_tlast;
        end
        adv_idx_reg  <= adv_idx_next;
        status_reg   <= status_next;
        olen_reg     <= olen_next;
        opay_reg     <= opay_next;
        buffered_reg <= buffered_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tuser   = status_reg;
    assign m_tdata   = {7'd0, stalls_reg, target_reg, buffered_reg, contig_reg,
                        opay_reg, olen_reg};
endmodule
